### src/distinct_value_counter_assert.svh
// ----------------------------------------------------------------------------
// distinct_value_counter assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_VALUE_COUNTER_ASSERT_SVH
`define DISTINCT_VALUE_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

`define DVC_ASSERT_SAME(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("dvc check failed in same cycle");

`define DVC_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("dvc check failed in next cycle");

`else

`define DVC_ASSERT_SAME(label, cond, expr)

`define DVC_ASSERT_NEXT(label, cond, expr)

`endif

`endif

### src/dvc_pkg.sv
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared constants, codes and types of the distinct value counter.
// ----------------------------------------------------------------------------
package dvc_pkg;

    localparam int DVC_TABLE_DEPTH = 256;
    localparam int DVC_COUNT_WIDTH = 32;

    localparam int VALUE_W     = 64;
    localparam int INDEX_W     = 8;
    localparam int OUT_COUNT_W = 32;
    localparam int TOTAL_W     = 9;
    localparam int STATUS_W    = 3;

    typedef enum logic
    {
        FUNC_ADD  = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_COUNTED      = 3'd0,
        ST_APPENDED     = 3'd1,
        ST_FULL         = 3'd2,
        ST_READ_OK      = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_RDDATA,
        S_EMIT
    } state_t;

    typedef struct packed
    {
        logic value_we;
        logic count_we;
    } mem_we_t;

endpackage

### src/dvc_if.sv
// ----------------------------------------------------------------------------
// dvc_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dvc_req_if
    import dvc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0]        read_index;

    modport source (output valid, output func, output sample_value, output read_index,
                    input ready);
    modport sink   (input valid, input func, input sample_value, input read_index,
                    output ready);
endinterface

interface dvc_rsp_if
    import dvc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] entry_value;
    logic [OUT_COUNT_W-1:0]    entry_count;
    logic [TOTAL_W-1:0]        distinct_total;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output entry_value, output entry_count,
                    output distinct_total, output status, input ready);
    modport sink   (input valid, input entry_value, input entry_count,
                    input distinct_total, input status, output ready);
endinterface

### src/dvc_ram.sv
// ----------------------------------------------------------------------------
// dvc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/dvc_ctrl.sv
// ----------------------------------------------------------------------------
// dvc_ctrl
// Sequencer: linear search over the value RAM, count update, append, read.
// ----------------------------------------------------------------------------
module dvc_ctrl
    import dvc_pkg::*;
#(
    parameter int TABLE_DEPTH = DVC_TABLE_DEPTH,
    parameter int COUNT_WIDTH = DVC_COUNT_WIDTH,
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int UW         = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    dvc_req_if.sink                   req,
    dvc_rsp_if.source                 rsp,
    output logic [IDX_W-1:0]          rd_addr,
    output logic [IDX_W-1:0]          wr_addr,
    output mem_we_t                   mem_we,
    output logic signed [VALUE_W-1:0] value_wdata,
    output logic [COUNT_WIDTH-1:0]    count_wdata,
    input  logic signed [VALUE_W-1:0] value_rdata,
    input  logic [COUNT_WIDTH-1:0]    count_rdata,
    output logic [UW-1:0]             used
);

    state_t                    state_reg,     state_next;
    logic [UW-1:0]             used_reg,      used_next;
    logic [UW-1:0]             issue_reg,     issue_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]          cmp_addr_reg,  cmp_addr_next;
    logic signed [VALUE_W-1:0] sample_reg,    sample_next;

    logic signed [VALUE_W-1:0] res_value_reg,  res_value_next;
    logic [COUNT_WIDTH-1:0]    res_count_reg,  res_count_next;
    status_t                   res_status_reg, res_status_next;

    logic                      out_valid_reg,  out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg,  out_value_next;
    logic [OUT_COUNT_W-1:0]    out_count_reg,  out_count_next;
    logic [TOTAL_W-1:0]        out_total_reg,  out_total_next;
    status_t                   out_status_reg, out_status_next;

    logic                      accept;
    logic                      in_range;
    logic                      hit;
    logic                      miss;
    logic                      out_free;
    logic [COUNT_WIDTH-1:0]    bumped_count;

    assign accept   = req.valid && req.ready;
    assign in_range = req.read_index < used_reg;
    assign hit      = (state_reg == S_SCAN) && cmp_valid_reg && (value_rdata == sample_reg);
    assign miss     = (state_reg == S_SCAN) && !cmp_valid_reg && (issue_reg >= used_reg);
    assign out_free = !out_valid_reg || rsp.ready;

    assign bumped_count = (count_rdata == {COUNT_WIDTH{1'b1}}) ? count_rdata
                                                               : count_rdata + COUNT_WIDTH'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == FUNC_READ)
                    begin
                        state_next = in_range ? S_RDDATA : S_EMIT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit || miss)
                begin
                    state_next = S_EMIT;
                end
            end
            S_RDDATA:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        used_next       = used_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_addr_next   = cmp_addr_reg;
        sample_next     = sample_reg;
        res_value_next  = res_value_reg;
        res_count_next  = res_count_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_total_next  = out_total_reg;
        out_status_next = out_status_reg;
        rd_addr         = IDX_W'(issue_reg);
        wr_addr         = cmp_addr_reg;
        mem_we          = '0;
        value_wdata     = sample_reg;
        count_wdata     = bumped_count;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next    = req.sample_value;
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                    rd_addr        = IDX_W'(req.read_index);
                    if ((req.func == FUNC_READ) && !in_range)
                    begin
                        res_value_next  = '0;
                        res_count_next  = '0;
                        res_status_next = ST_OUT_OF_RANGE;
                    end
                end
            end
            S_SCAN:
            begin
                cmp_valid_next = issue_reg < used_reg;
                if (issue_reg < used_reg)
                begin
                    issue_next    = issue_reg + UW'(1);
                    cmp_addr_next = IDX_W'(issue_reg);
                end
                if (hit)
                begin
                    mem_we.count_we = 1'b1;
                    res_value_next  = value_rdata;
                    res_count_next  = bumped_count;
                    res_status_next = ST_COUNTED;
                end
                else if (miss)
                begin
                    res_value_next = sample_reg;
                    if (used_reg < TABLE_DEPTH)
                    begin
                        wr_addr         = IDX_W'(used_reg);
                        count_wdata     = COUNT_WIDTH'(1);
                        mem_we.value_we = 1'b1;
                        mem_we.count_we = 1'b1;
                        used_next       = used_reg + UW'(1);
                        res_count_next  = COUNT_WIDTH'(1);
                        res_status_next = ST_APPENDED;
                    end
                    else
                    begin
                        res_count_next  = '0;
                        res_status_next = ST_FULL;
                    end
                end
            end
            S_RDDATA:
            begin
                res_value_next  = value_rdata;
                res_count_next  = count_rdata;
                res_status_next = ST_READ_OK;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_count_next  = OUT_COUNT_W'(res_count_reg);
                    out_total_next  = TOTAL_W'(used_reg);
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg      <= issue_next;
        cmp_addr_reg   <= cmp_addr_next;
        sample_reg     <= sample_next;
        res_value_reg  <= res_value_next;
        res_count_reg  <= res_count_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_total_reg  <= out_total_next;
        out_status_reg <= out_status_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.entry_value    = out_value_reg;
    assign rsp.entry_count    = out_count_reg;
    assign rsp.distinct_total = out_total_reg;
    assign rsp.status         = out_status_reg;
    assign used               = used_reg;

endmodule

### src/distinct_value_counter.sv
// ----------------------------------------------------------------------------
// distinct_value_counter
// Counts occurrences of distinct signed values in first-appearance order.
//
//   channel  role  payload
//   req      sink  func, sample_value, read_index
//   rsp      src   entry_value, entry_count, distinct_total, status
//
// An add request walks the value RAM read port one entry per cycle until a
// hit or until all used entries are passed. A read goes through S_RDDATA, or
// straight to S_EMIT when the index is out of range. One request is in
// flight at a time; a new request is taken while the previous response
// waits in the output register, and holds in S_EMIT until that register
// drains. Reset clears the state, fill count and valid flags, not the RAMs.
// ----------------------------------------------------------------------------
`include "distinct_value_counter_assert.svh"

module distinct_value_counter
    import dvc_pkg::*;
#(
    parameter int TABLE_DEPTH = DVC_TABLE_DEPTH,
    parameter int COUNT_WIDTH = DVC_COUNT_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    dvc_req_if.sink   req,
    dvc_rsp_if.source rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int UW    = $clog2(TABLE_DEPTH + 1);

    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    mem_we_t                   mem_we;
    logic signed [VALUE_W-1:0] value_wdata;
    logic [COUNT_WIDTH-1:0]    count_wdata;
    logic signed [VALUE_W-1:0] value_rdata;
    logic [COUNT_WIDTH-1:0]    count_rdata;
    logic [UW-1:0]             used;

    dvc_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .mem_we      (mem_we),
        .value_wdata (value_wdata),
        .count_wdata (count_wdata),
        .value_rdata (value_rdata),
        .count_rdata (count_rdata),
        .used        (used)
    );

    dvc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (mem_we.value_we),
        .waddr (wr_addr),
        .wdata (value_wdata),
        .raddr (rd_addr),
        .rdata (value_rdata)
    );

    dvc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (mem_we.count_we),
        .waddr (wr_addr),
        .wdata (count_wdata),
        .raddr (rd_addr),
        .rdata (count_rdata)
    );

    `DVC_ASSERT_SAME(a_append_writes_both, mem_we.value_we, mem_we.count_we)
    `DVC_ASSERT_SAME(a_no_write_on_accept, req.valid && req.ready, !mem_we.count_we)
    `DVC_ASSERT_NEXT(a_append_grows_fill, mem_we.value_we, used == $past(used) + UW'(1))
    `DVC_ASSERT_SAME(a_fill_bounded, 1'b1, used <= TABLE_DEPTH)

endmodule
